/* hdl/reld_pkg.sv */
package reld_pkg;

   // field widths
   localparam int ID_W       = 32;
   localparam int TIME_W     = 32;
   localparam int COUNT_W    = 16;
   localparam int DEPTH_W    = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   // saturation value of a repeat count
   localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

   // register reset values
   localparam logic [COUNT_W-1:0] LIMIT_RESET = 16'd10;
   localparam logic [DEPTH_W-1:0] DEPTH_RESET = 4'd8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_LIMIT  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH_IN_USE = 1'b1;

   // request kinds
   typedef enum logic {
      REQ_UPDATE = 1'b0,
      REQ_ERASE  = 1'b1
   } req_kind_type;

   typedef struct packed {
      req_kind_type        req_type;
      logic [ID_W-1:0]     event_id;
      logic [TIME_W-1:0]   event_time;
   } req_item_type;

   typedef struct packed {
      logic                looping;
      logic [COUNT_W-1:0]  max_count;
      logic                was_present;
   } rsp_item_type;

   // one history entry as held in the slot memory
   typedef struct packed {
      logic [ID_W-1:0]     ent_id;
      logic [COUNT_W-1:0]  ent_count;
      logic [TIME_W-1:0]   ent_time;
   } slot_entry_type;

   // control of the rank list for one request
   typedef struct packed {
      logic apply;
      logic grow;
      logic shrink;
   } rank_ctl_type;

endpackage

/* hdl/reld_slot_ram.sv */
module reld_slot_ram #(
   parameter int DEPTH = 8,
   parameter int AW    = 3
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [AW-1:0]            wr_addr,
   input  reld_pkg::slot_entry_type wr_data,
   input  logic [AW-1:0]            rd_addr,
   output reld_pkg::slot_entry_type rd_data
);

   reld_pkg::slot_entry_type mem [DEPTH];
   reld_pkg::slot_entry_type rd_data_ff;

   // write one entry, read one entry with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/reld_rank_list.sv */
module reld_rank_list #(
   parameter int MAX_DEPTH = 8,
   parameter int IDX_W     = 3,
   parameter int CNT_W     = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  reld_pkg::rank_ctl_type ctl,
   input  logic [IDX_W-1:0]       idx,
   input  logic [IDX_W-1:0]       dst_idx,
   output logic [IDX_W-1:0]       rd_slot,
   output logic [CNT_W-1:0]       occ
);

   // rank_ff is a permutation of all slots: positions below occ_ff hold the
   // entries newest first, the positions above hold the free slots
   logic [IDX_W-1:0] rank_ff [MAX_DEPTH];
   logic [IDX_W-1:0] rank_in [MAX_DEPTH];
   logic [IDX_W-1:0] above_w [MAX_DEPTH];
   logic [IDX_W-1:0] below_w [MAX_DEPTH];
   logic [CNT_W-1:0] occ_ff;
   logic [CNT_W-1:0] occ_in;

   // neighbors of each position
   for (genvar g = 0; g < MAX_DEPTH; g++) begin : g_nbr
      if (g < MAX_DEPTH - 1) begin : g_up
         assign above_w[g] = rank_ff[g + 1];
      end else begin : g_top
         assign above_w[g] = rank_ff[g];
      end
      if (g > 0) begin : g_dn
         assign below_w[g] = rank_ff[g - 1];
      end else begin : g_bot
         assign below_w[g] = rank_ff[g];
      end
   end

   assign rd_slot = rank_ff[idx];

   // move the slot at idx to dst_idx, shifting the positions in between
   always_comb begin
      logic [IDX_W-1:0] kk;
      for (int k = 0; k < MAX_DEPTH; k++) begin
         kk = IDX_W'(k);
         if (!ctl.apply) begin
            rank_in[k] = rank_ff[k];
         end else if (kk == dst_idx) begin
            rank_in[k] = rd_slot;
         end else if (idx < dst_idx && kk >= idx && kk < dst_idx) begin
            rank_in[k] = above_w[k];
         end else if (idx > dst_idx && kk > dst_idx && kk <= idx) begin
            rank_in[k] = below_w[k];
         end else begin
            rank_in[k] = rank_ff[k];
         end
      end
   end

   // adjust occupancy
   always_comb begin
      occ_in = occ_ff;
      if (ctl.apply && ctl.grow) begin
         occ_in = occ_ff + CNT_W'(1);
      end else if (ctl.apply && ctl.shrink) begin
         occ_in = occ_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_DEPTH; k++) begin
            rank_ff[k] <= IDX_W'(k);
         end
         occ_ff <= '0;
      end else begin
         rank_ff <= rank_in;
         occ_ff  <= occ_in;
      end
   end

   assign occ = occ_ff;

endmodule

/* hdl/repeat_event_loop_detector.sv */
// Repeat event loop detector. A request is taken when start is high and busy
// is low; busy stays high until the result is computed, and the result then
// appears for one cycle with rsp_strobe, in the same cycle that busy drops, so
// the receiver must take it at once. The next request can be taken in the strobe
// cycle. The scan over the slot memory reads one history entry per cycle through
// its single read port, then waits for the last read to return and closes the
// scan, followed by a write-back cycle. After reset the history is empty at once;
// no clearing pass is needed. Configuration writes are always taken (csr_ready is
// high) and are meant for idle periods.
module repeat_event_loop_detector #(
   parameter int MAX_DEPTH = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  reld_pkg::req_item_type              req_data,
   output logic                                rsp_strobe,
   output reld_pkg::rsp_item_type              rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [reld_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [reld_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int CNT_W = $clog2(MAX_DEPTH + 1);
   localparam int CMP_W = (CNT_W > reld_pkg::DEPTH_W) ? CNT_W : reld_pkg::DEPTH_W;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type                          state_ff, state_in;
   reld_pkg::req_item_type             req_ff, req_in;
   logic [reld_pkg::COUNT_W-1:0]       limit_ff, limit_in;
   logic [reld_pkg::DEPTH_W-1:0]       depth_ff, depth_in;
   logic [reld_pkg::COUNT_W-1:0]       peak_ff, peak_in;
   logic                               flag_ff, flag_in;
   logic                               rsp_strobe_ff, rsp_strobe_in;
   reld_pkg::rsp_item_type             rsp_ff, rsp_in;

   logic [CNT_W-1:0]                   iss_ff, iss_in;
   logic                               pend_ff, pend_in;
   logic [IDX_W-1:0]                   pend_pos_ff, pend_pos_in;
   logic [IDX_W-1:0]                   pend_slot_ff, pend_slot_in;
   logic                               found_ff, found_in;
   logic [IDX_W-1:0]                   hit_pos_ff, hit_pos_in;
   logic [IDX_W-1:0]                   hit_slot_ff, hit_slot_in;
   logic [reld_pkg::COUNT_W-1:0]       hit_cnt_ff, hit_cnt_in;
   logic [CNT_W-1:0]                   pos_upd_ff, pos_upd_in;
   logic [CNT_W-1:0]                   pos_ins_ff, pos_ins_in;
   logic [reld_pkg::COUNT_W-1:0]       max_other_ff, max_other_in;
   logic                               evict_ff, evict_in;

   reld_pkg::rank_ctl_type             rank_ctl;
   logic [IDX_W-1:0]                   rank_idx;
   logic [IDX_W-1:0]                   rank_dst;
   logic [IDX_W-1:0]                   rank_slot;
   logic [CNT_W-1:0]                   occ;

   logic                               ram_wr_en;
   logic [IDX_W-1:0]                   ram_wr_addr;
   reld_pkg::slot_entry_type           ram_wr_data;
   reld_pkg::slot_entry_type           ram_rd_data;

   logic [CMP_W-1:0]                   depth_eff;
   logic                               evict_now;
   logic [IDX_W-1:0]                   last_idx;
   logic                               issue;
   logic [reld_pkg::COUNT_W-1:0]       new_cnt;
   logic [reld_pkg::COUNT_W-1:0]       peak_upd;

   reld_slot_ram #(
      .DEPTH (MAX_DEPTH),
      .AW    (IDX_W)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (rank_slot),
      .rd_data (ram_rd_data)
   );

   reld_rank_list #(
      .MAX_DEPTH (MAX_DEPTH),
      .IDX_W     (IDX_W),
      .CNT_W     (CNT_W)
   ) u_rank_list (
      .clock   (clock),
      .reset   (reset),
      .ctl     (rank_ctl),
      .idx     (rank_idx),
      .dst_idx (rank_dst),
      .rd_slot (rank_slot),
      .occ     (occ)
   );

   // clamp the depth in use and decide on eviction
   assign depth_eff = (CMP_W'(depth_ff) > CMP_W'(MAX_DEPTH)) ? CMP_W'(MAX_DEPTH)
                                                              : CMP_W'(depth_ff);
   assign evict_now = (occ != '0) && (CMP_W'(occ) >= depth_eff);
   assign last_idx  = IDX_W'(occ - CNT_W'(1));
   assign issue     = (state_ff == ST_SCAN) && (iss_ff < occ);

   // saturating count of the matched entry and the raised peak
   assign new_cnt  = (hit_cnt_ff == reld_pkg::COUNT_MAX) ? hit_cnt_ff
                                                         : hit_cnt_ff + reld_pkg::COUNT_W'(1);
   assign peak_upd = (new_cnt > peak_ff) ? new_cnt : peak_ff;

   // configuration writes
   assign csr_ready = 1'b1;

   always_comb begin
      limit_in = limit_ff;
      depth_in = depth_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            reld_pkg::CSR_COUNT_LIMIT:  limit_in = csr_wdata;
            reld_pkg::CSR_DEPTH_IN_USE: depth_in = csr_wdata[reld_pkg::DEPTH_W-1:0];
            default: ;
         endcase
      end
   end

   // request sequencer: scan the history, then write back
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      peak_in       = peak_ff;
      flag_in       = flag_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      iss_in        = iss_ff;
      pend_in       = 1'b0;
      pend_pos_in   = pend_pos_ff;
      pend_slot_in  = pend_slot_ff;
      found_in      = found_ff;
      hit_pos_in    = hit_pos_ff;
      hit_slot_in   = hit_slot_ff;
      hit_cnt_in    = hit_cnt_ff;
      pos_upd_in    = pos_upd_ff;
      pos_ins_in    = pos_ins_ff;
      max_other_in  = max_other_ff;
      evict_in      = evict_ff;
      rank_ctl      = '0;
      rank_idx      = iss_ff[IDX_W-1:0];
      rank_dst      = '0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = rank_slot;
      ram_wr_data   = '0;

      unique case (state_ff)
         ST_IDLE: begin
            // take a request and clear the scan accumulators
            if (start) begin
               req_in       = req_data;
               evict_in     = evict_now;
               iss_in       = '0;
               found_in     = 1'b0;
               pos_upd_in   = '0;
               pos_ins_in   = '0;
               max_other_in = '0;
               state_in     = ST_SCAN;
            end
         end

         ST_SCAN: begin
            // issue one read per cycle in rank order
            if (issue) begin
               iss_in       = iss_ff + CNT_W'(1);
               pend_in      = 1'b1;
               pend_pos_in  = iss_ff[IDX_W-1:0];
               pend_slot_in = rank_slot;
            end
            // fold the returned entry into the accumulators
            if (pend_ff) begin
               if (!found_ff && ram_rd_data.ent_id == req_ff.event_id) begin
                  found_in    = 1'b1;
                  hit_pos_in  = pend_pos_ff;
                  hit_slot_in = pend_slot_ff;
                  hit_cnt_in  = ram_rd_data.ent_count;
               end else begin
                  if (ram_rd_data.ent_time > req_ff.event_time ||
                      (ram_rd_data.ent_time == req_ff.event_time && !found_ff)) begin
                     pos_upd_in = pos_upd_ff + CNT_W'(1);
                  end
                  if (ram_rd_data.ent_count > max_other_ff) begin
                     max_other_in = ram_rd_data.ent_count;
                  end
               end
               if (!(evict_ff && pend_pos_ff == last_idx) &&
                   ram_rd_data.ent_time >= req_ff.event_time) begin
                  pos_ins_in = pos_ins_ff + CNT_W'(1);
               end
            end
            if (!issue && !pend_ff) begin
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            unique case (req_ff.req_type)
               reld_pkg::REQ_ERASE: begin
                  // drop the entry and take the peak over what remains
                  peak_in = max_other_ff;
                  flag_in = max_other_ff > limit_ff;
                  if (found_ff) begin
                     rank_ctl.apply  = 1'b1;
                     rank_ctl.shrink = 1'b1;
                     rank_idx        = hit_pos_ff;
                     rank_dst        = last_idx;
                  end
               end
               reld_pkg::REQ_UPDATE: begin
                  if (found_ff) begin
                     // refresh the entry and move it to its new rank
                     ram_wr_en             = 1'b1;
                     ram_wr_addr           = hit_slot_ff;
                     ram_wr_data.ent_id    = req_ff.event_id;
                     ram_wr_data.ent_count = new_cnt;
                     ram_wr_data.ent_time  = req_ff.event_time;
                     peak_in               = peak_upd;
                     flag_in               = flag_ff || (peak_upd > limit_ff);
                     rank_ctl.apply        = 1'b1;
                     rank_idx              = hit_pos_ff;
                     rank_dst              = pos_upd_ff[IDX_W-1:0];
                  end else begin
                     // reuse the oldest slot or take the first free one
                     rank_idx              = evict_ff ? last_idx : occ[IDX_W-1:0];
                     rank_dst              = pos_ins_ff[IDX_W-1:0];
                     rank_ctl.apply        = 1'b1;
                     rank_ctl.grow         = !evict_ff;
                     ram_wr_en             = 1'b1;
                     ram_wr_addr           = rank_slot;
                     ram_wr_data.ent_id    = req_ff.event_id;
                     ram_wr_data.ent_count = reld_pkg::COUNT_W'(1);
                     ram_wr_data.ent_time  = req_ff.event_time;
                  end
               end
               default: ;
            endcase
            rsp_in.looping     = flag_in;
            rsp_in.max_count   = peak_in;
            rsp_in.was_present = found_ff;
            rsp_strobe_in      = 1'b1;
            state_in           = ST_IDLE;
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         limit_ff      <= reld_pkg::LIMIT_RESET;
         depth_ff      <= reld_pkg::DEPTH_RESET;
         peak_ff       <= '0;
         flag_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         pend_ff       <= 1'b0;
         found_ff      <= 1'b0;
         iss_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         limit_ff      <= limit_in;
         depth_ff      <= depth_in;
         peak_ff       <= peak_in;
         flag_ff       <= flag_in;
         rsp_strobe_ff <= rsp_strobe_in;
         pend_ff       <= pend_in;
         found_ff      <= found_in;
         iss_ff        <= iss_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      rsp_ff       <= rsp_in;
      pend_pos_ff  <= pend_pos_in;
      pend_slot_ff <= pend_slot_in;
      hit_pos_ff   <= hit_pos_in;
      hit_slot_ff  <= hit_slot_in;
      hit_cnt_ff   <= hit_cnt_in;
      pos_upd_ff   <= pos_upd_in;
      pos_ins_ff   <= pos_ins_in;
      max_other_ff <= max_other_in;
      evict_ff     <= evict_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // a result follows the write-back cycle and never overlaps a busy cycle
   a_strobe_after_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> ($past(state_ff == ST_FINISH) && !busy))
      else $error("result strobe without a write-back cycle");

   // read data is only pending while scanning
   a_pend_in_scan: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == ST_SCAN))
      else $error("slot read pending outside the scan");

   // the history size holds still during a scan
   a_occ_stable_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && $past(state_ff == ST_SCAN)) |-> $stable(occ))
      else $error("occupancy changed during the scan");

   // a successful erase shrinks the history by one
   a_erase_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && req_ff.req_type == reld_pkg::REQ_ERASE && found_ff)
      |=> (occ == $past(occ) - CNT_W'(1)))
      else $error("erase did not remove the entry");

endmodule

/* tb/reld_history_checker.sv */
module reld_history_checker #(
   parameter int MAX_DEPTH = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  reld_pkg::req_item_type          req_data,
   input  logic                            rsp_strobe,
   input  reld_pkg::rsp_item_type          rsp_data,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [reld_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [reld_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              fail_count,
   output int                              outstanding
);

   localparam int DUE_DEPTH = 4;

   // shadow copy of the history table, newest first through h_order
   logic [reld_pkg::ID_W-1:0]    h_id    [MAX_DEPTH];
   logic [reld_pkg::COUNT_W-1:0] h_cnt   [MAX_DEPTH];
   logic [reld_pkg::TIME_W-1:0]  h_stamp [MAX_DEPTH];
   logic                         h_used  [MAX_DEPTH];
   int unsigned                  h_order [MAX_DEPTH];
   logic [reld_pkg::COUNT_W-1:0] run_peak;
   logic                         loop_seen;

   // shadow copy of the registers
   logic [reld_pkg::COUNT_W-1:0] lim_cfg;
   logic [reld_pkg::DEPTH_W-1:0] depth_cfg;

   // results still owed by the block, oldest first
   reld_pkg::rsp_item_type       due_results [DUE_DEPTH];
   int unsigned                  due_wr = 0;
   int unsigned                  due_rd = 0;
   int                           errs = 0;

   // Apply one request to the shadow table and work out its result.
   task automatic advance_history(input reld_pkg::req_item_type rq,
                                  output reld_pkg::rsp_item_type rs);
      int unsigned n;
      int unsigned r;
      int unsigned f;
      int unsigned s;
      int unsigned j;
      int unsigned k;
      int unsigned key;
      int unsigned eff;
      logic        hit;
      n = 0;
      for (s = 0; s < MAX_DEPTH; s++)
         if (h_used[s]) n++;

      // search newest to oldest
      hit = 1'b0;
      r = 0;
      while (r < n && !hit) begin
         if (h_id[h_order[r]] == rq.event_id) hit = 1'b1;
         else r++;
      end

      if (rq.req_type == reld_pkg::REQ_UPDATE) begin
         if (hit) begin
            // bump the count, saturating, and refresh the stamp
            s = h_order[r];
            if (h_cnt[s] != reld_pkg::COUNT_MAX) h_cnt[s] = h_cnt[s] + 1'b1;
            h_stamp[s] = rq.event_time;
            if (h_cnt[s] > run_peak) run_peak = h_cnt[s];
            if (run_peak > lim_cfg) loop_seen = 1'b1;
         end else begin
            // evict the oldest once full, then insert into the first free slot
            eff = (depth_cfg > MAX_DEPTH) ? MAX_DEPTH : depth_cfg;
            if (n > 0 && n >= eff) begin
               h_used[h_order[n-1]] = 1'b0;
               n--;
            end
            f = 0;
            while (f < MAX_DEPTH && h_used[f]) f++;
            if (f < MAX_DEPTH && n < MAX_DEPTH) begin
               h_id[f]    = rq.event_id;
               h_cnt[f]   = reld_pkg::COUNT_W'(1);
               h_stamp[f] = rq.event_time;
               h_used[f]  = 1'b1;
               h_order[n] = f;
               n++;
            end
         end
         // stable insertion sort, newest stamp first
         for (k = 1; k < n; k++) begin
            key = h_order[k];
            j = k;
            while (j > 0 && h_stamp[h_order[j-1]] < h_stamp[key]) begin
               h_order[j] = h_order[j-1];
               j--;
            end
            h_order[j] = key;
         end
      end else begin
         // drop the entry and close the gap in the order
         if (hit) begin
            h_used[h_order[r]] = 1'b0;
            for (k = r; k + 1 < n; k++)
               h_order[k] = h_order[k+1];
            n--;
         end
         // rebuild peak and flag from what is left
         run_peak = '0;
         for (k = 0; k < n; k++)
            if (h_cnt[h_order[k]] > run_peak) run_peak = h_cnt[h_order[k]];
         loop_seen = (run_peak > lim_cfg);
      end

      rs.looping     = loop_seen;
      rs.max_count   = run_peak;
      rs.was_present = hit;
   endtask

   always @(posedge clock) begin
      reld_pkg::rsp_item_type want;
      int unsigned            s;
      if (reset) begin
         for (s = 0; s < MAX_DEPTH; s++) begin
            h_id[s]    = '0;
            h_cnt[s]   = '0;
            h_stamp[s] = '0;
            h_used[s]  = 1'b0;
            h_order[s] = 0;
         end
         run_peak  = '0;
         loop_seen = 1'b0;
         lim_cfg   = reld_pkg::LIMIT_RESET;
         depth_cfg = reld_pkg::DEPTH_RESET;
         due_wr    = 0;
         due_rd    = 0;
      end else begin
         // track register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               reld_pkg::CSR_COUNT_LIMIT:  lim_cfg   = csr_wdata[reld_pkg::COUNT_W-1:0];
               reld_pkg::CSR_DEPTH_IN_USE: depth_cfg = csr_wdata[reld_pkg::DEPTH_W-1:0];
               default: ;
            endcase
         end

         // predict on each request transfer
         if (start && !busy) begin
            advance_history(req_data, want);
            if (due_wr - due_rd >= DUE_DEPTH) begin
               $error("more requests outstanding than the block can hold");
               errs++;
            end else begin
               due_results[due_wr % DUE_DEPTH] = want;
               due_wr++;
            end
         end

         // compare each strobed result with the oldest prediction
         if (rsp_strobe) begin
            if (due_wr == due_rd) begin
               $error("result strobe with no request outstanding");
               errs++;
            end else begin
               want = due_results[due_rd % DUE_DEPTH];
               due_rd++;
               if (rsp_data.looping !== want.looping) begin
                  $error("looping: expected %0d, got %0d", want.looping, rsp_data.looping);
                  errs++;
               end
               if (rsp_data.max_count !== want.max_count) begin
                  $error("max_count: expected %0d, got %0d",
                         want.max_count, rsp_data.max_count);
                  errs++;
               end
               if (rsp_data.was_present !== want.was_present) begin
                  $error("was_present: expected %0d, got %0d",
                         want.was_present, rsp_data.was_present);
                  errs++;
               end
            end
         end
      end
      outstanding <= int'(due_wr - due_rd);
      fail_count  <= errs;
   end

endmodule

/* tb/repeat_event_loop_detector_tb.sv */
module repeat_event_loop_detector_tb;

   localparam int MAX_DEPTH   = 8;
   localparam int IDLE_LIMIT  = 2000;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 192;
   localparam int POOL        = 12;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            start = 1'b0;
   logic                            busy;
   reld_pkg::req_item_type          req_data = '0;
   logic                            rsp_strobe;
   reld_pkg::rsp_item_type          rsp_data;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [reld_pkg::CSR_IDX_W-1:0]  csr_index = reld_pkg::CSR_COUNT_LIMIT;
   logic [reld_pkg::CSR_DATA_W-1:0] csr_wdata = '0;
   int                              fail_count;
   int                              outstanding;

   int                              idle_cycles = 0;
   logic [reld_pkg::TIME_W-1:0]     stamp_now = '0;
   logic [reld_pkg::ID_W-1:0]       id_pool [POOL];
   int                              n_sent = 0;
   int                              n_erase = 0;
   int                              n_settings = 0;
   logic                            burst = 1'b0;

   repeat_event_loop_detector #(.MAX_DEPTH(MAX_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   reld_history_checker #(.MAX_DEPTH(MAX_DEPTH)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // end the run when no transfer of any kind happens for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("[repeat_event_loop_detector] ERROR");
            $finish;
         end
      end
   end

   function automatic reld_pkg::req_item_type make_req(
      input reld_pkg::req_kind_type kind,
      input logic [reld_pkg::ID_W-1:0] id,
      input logic [reld_pkg::TIME_W-1:0] stamp);
      reld_pkg::req_item_type item;
      item.req_type   = kind;
      item.event_id   = id;
      item.event_time = stamp;
      return item;
   endfunction

   // Hold start through the transfer; keep it high when the next item follows at once.
   task automatic send_req(input reld_pkg::req_item_type item, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      n_sent++;
      if (item.req_type == reld_pkg::REQ_ERASE) n_erase++;
   endtask

   // Drop start and wait for every owed result.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Write both registers back to back, then drop valid.
   task automatic set_regs(input logic [reld_pkg::COUNT_W-1:0] limit,
                           input logic [reld_pkg::CSR_DATA_W-1:0] depth_word);
      csr_valid <= 1'b1;
      csr_index <= reld_pkg::CSR_COUNT_LIMIT;
      csr_wdata <= limit;
      do @(posedge clock); while (!csr_ready);
      csr_index <= reld_pkg::CSR_DEPTH_IN_USE;
      csr_wdata <= depth_word;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      n_settings++;
   endtask

   initial begin
      int                           ph;
      int                           i;
      int                           k;
      int                           pick;
      int                           step;
      logic [reld_pkg::COUNT_W-1:0] lim;
      logic [reld_pkg::DEPTH_W-1:0] dep;
      reld_pkg::req_kind_type       kind;
      logic [reld_pkg::ID_W-1:0]    id;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: insert, hit, extreme id and stamp, tied stamps, eviction, erase
      set_regs(reld_pkg::LIMIT_RESET, {12'h000, reld_pkg::DEPTH_RESET});
      send_req(make_req(reld_pkg::REQ_UPDATE, 32'h0000_0000, 32'h0000_0000), 0);
      send_req(make_req(reld_pkg::REQ_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
               $urandom_range(0, 5));
      // stamp goes backwards on a hit
      send_req(make_req(reld_pkg::REQ_UPDATE, 32'h0000_0000, 32'd5), $urandom_range(0, 5));
      for (k = 1; k <= 7; k++)
         send_req(make_req(reld_pkg::REQ_UPDATE, k, 32'd5), $urandom_range(0, 5));
      // table full: this one evicts the oldest
      send_req(make_req(reld_pkg::REQ_UPDATE, 32'd8, 32'd6), 0);
      send_req(make_req(reld_pkg::REQ_ERASE, 32'h1234_5678, 32'd6), $urandom_range(0, 5));
      send_req(make_req(reld_pkg::REQ_ERASE, 32'd3, 32'd6), $urandom_range(0, 5));
      drain();

      // directed: looping on low limit, erase recompute, depth of zero evicting on each insert
      set_regs(16'd1, 16'hFFF0);
      send_req(make_req(reld_pkg::REQ_UPDATE, 32'd5, 32'd7), 0);
      send_req(make_req(reld_pkg::REQ_UPDATE, 32'd5, 32'd7), 0);
      send_req(make_req(reld_pkg::REQ_ERASE, 32'd5, 32'd7), $urandom_range(0, 5));
      send_req(make_req(reld_pkg::REQ_UPDATE, 32'd99, 32'd8), $urandom_range(0, 5));
      send_req(make_req(reld_pkg::REQ_UPDATE, 32'd100, 32'd8), 0);
      drain();

      // directed: top limit, depth above capacity
      set_regs(16'hFFFF, 16'h0A5F);
      send_req(make_req(reld_pkg::REQ_UPDATE, 32'd100, 32'd9), 0);
      send_req(make_req(reld_pkg::REQ_ERASE, 32'd100, 32'd9), $urandom_range(0, 5));
      send_req(make_req(reld_pkg::REQ_ERASE, 32'd77, 32'd9), $urandom_range(0, 5));
      drain();

      // random phases, one register setting each
      stamp_now = 32'd10;
      for (ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin lim = reld_pkg::LIMIT_RESET; dep = reld_pkg::DEPTH_RESET; end
            1: begin lim = 16'd0;       dep = 4'd1;        end
            2: begin lim = 16'hFFFF;    dep = 4'd15;       end
            3: begin lim = 16'd3;       dep = 4'd0;        end
            4: begin lim = 16'd1;       dep = 4'd4;        end
            5: begin lim = 16'($urandom); dep = 4'd9;      end
            6: begin
               lim = 16'($urandom_range(0, 20));
               dep = 4'($urandom_range(0, 15));
            end
            default: begin lim = 16'd10; dep = 4'd8; end
         endcase
         set_regs(lim, {12'($urandom), dep});
         for (k = 0; k < POOL; k++) id_pool[k] = $urandom;

         for (i = 0; i < PHASE_ITEMS; i++) begin
            if (i % 40 == 0) burst = ($urandom_range(0, 3) == 0);
            // let the block run dry once mid-phase
            if (ph == 3 && i == PHASE_ITEMS / 2) drain();

            kind = ($urandom_range(0, 99) < 25) ? reld_pkg::REQ_ERASE : reld_pkg::REQ_UPDATE;
            // one hot id collects repeats; erases rarely hit it
            pick = $urandom_range(0, 99);
            if (pick < 25)
               id = (kind == reld_pkg::REQ_ERASE) ? id_pool[$urandom_range(0, POOL-1)]
                                                  : id_pool[0];
            else if (pick < 88)
               id = id_pool[$urandom_range(1, POOL-1)];
            else
               id = $urandom;

            // stamps mostly advance, sometimes tie, sometimes jump anywhere
            step = $urandom_range(0, 99);
            if (step < 80)
               stamp_now = stamp_now + $urandom_range(0, 3);
            else if (step >= 90)
               stamp_now = $urandom;

            send_req(make_req(kind, id, stamp_now), burst ? 0 : $urandom_range(0, 5));
         end
         drain();
      end

      repeat (MAX_DEPTH + 4) @(posedge clock);
      $display("Sent %0d requests (%0d erases) across %0d register settings;",
               n_sent, n_erase, n_settings);
      $display("limits from 0 to 65535, depths 0 to 15, stamps advancing, tied and jumping.");
      if (fail_count == 0 && outstanding == 0)
         $display("[repeat_event_loop_detector] OK");
      else
         $display("[repeat_event_loop_detector] ERROR");
      $finish;
   end

endmodule
